### rtl/ris_pkg.sv
// shared types and constants for the register interval set
`default_nettype none

package ris_pkg;

    localparam int MAX_INTERVALS_DEF = 64;
    localparam int INDEX_BITS_DEF    = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ABSORB = 2'd1,
        CELL_INSERT = 2'd2
    } cell_op_t;

    typedef struct packed {
        action_t      action;
        logic [15:0]  index_low;
        logic [15:0]  index_high;
    } item_t;

    typedef struct packed {
        logic         hit;
        logic [15:0]  interval_end;
        logic         overflow;
        logic [6:0]   interval_count;
    } result_t;

    typedef struct packed {
        logic below;
        logic joins;
        logic hit;
    } cell_stat_t;

endpackage

`default_nettype wire

### rtl/ris_cell.sv
// one interval cell: holds one stored interval and shifts with its neighbors
`default_nettype none

module ris_cell
    import ris_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)(
    input  wire                   clk,
    input  wire cell_op_t         op,
    input  wire                   valid,
    input  wire [INDEX_BITS-1:0]  rng_lo,
    input  wire [INDEX_BITS-1:0]  rng_hi,
    input  wire                   prev_below,
    input  wire [INDEX_BITS-1:0]  prev_lo,
    input  wire [INDEX_BITS-1:0]  prev_hi,
    input  wire [INDEX_BITS-1:0]  next_lo,
    input  wire [INDEX_BITS-1:0]  next_hi,
    output logic [INDEX_BITS-1:0] lo,
    output logic [INDEX_BITS-1:0] hi,
    output cell_stat_t            stat
);

    logic [INDEX_BITS-1:0] lo_reg, lo_next;
    logic [INDEX_BITS-1:0] hi_reg, hi_next;
    logic [INDEX_BITS:0]   hi_inc, rhi_inc;

    assign lo = lo_reg;
    assign hi = hi_reg;

    // compares against the pending range, no wrap
    always_comb
    begin
        hi_inc     = {1'b0, hi_reg} + 1'b1;
        rhi_inc    = {1'b0, rng_hi} + 1'b1;
        stat.below = valid && (hi_inc < {1'b0, rng_lo});
        stat.joins = valid && !stat.below && !({1'b0, lo_reg} > rhi_inc);
        stat.hit   = valid && (rng_lo >= lo_reg) && (rng_lo <= hi_reg);
    end

    // shift left to drop an absorbed interval, right to open a slot
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        case (op)
            CELL_ABSORB:
            begin
                if (!stat.below)
                begin
                    lo_next = next_lo;
                    hi_next = next_hi;
                end
            end
            CELL_INSERT:
            begin
                if (!stat.below)
                begin
                    if (prev_below)
                    begin
                        lo_next = rng_lo;
                        hi_next = rng_hi;
                    end
                    else
                    begin
                        lo_next = prev_lo;
                        hi_next = prev_hi;
                    end
                end
            end
            default:
            begin
                lo_next = lo_reg;
                hi_next = hi_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

`default_nettype wire

### rtl/register_interval_set.sv
// top level of the register interval set: control sequencer and cell chain
//
// An item is taken when start is high and busy is low; its result appears on
// result for one cycle with done high, and must be captured then. Clear, query
// and the unused action load the item into the work state, from which result
// and done are registered. An add stays in the work state while stored
// intervals join the pending range, folding one joined interval per cycle
// before the final insert. The next item can start in the cycle done is high.
`default_nettype none

module register_interval_set
    import ris_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire item_t   item,
    output logic         busy,
    output logic         done,
    output result_t      result
);

    localparam int CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t                state_reg, state_next;
    action_t               action_reg, action_next;
    logic [INDEX_BITS-1:0] rng_lo_reg, rng_lo_next;
    logic [INDEX_BITS-1:0] rng_hi_reg, rng_hi_next;
    logic                  joined_reg, joined_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    cell_op_t              op;

    logic [INDEX_BITS-1:0] cell_lo [MAX_INTERVALS];
    logic [INDEX_BITS-1:0] cell_hi [MAX_INTERVALS];
    cell_stat_t            stat    [MAX_INTERVALS];
    logic [MAX_INTERVALS-1:0] valid;

    logic                  any_join, any_hit;
    logic [INDEX_BITS-1:0] join_lo, join_hi, hit_hi, miss_end;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // cell chain
    for (genvar k = 0; k < MAX_INTERVALS; k++)
    begin : g_cell
        assign valid[k] = (CW'(k) < count_reg);
        ris_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
            .clk        (clk),
            .op         (op),
            .valid      (valid[k]),
            .rng_lo     (rng_lo_reg),
            .rng_hi     (rng_hi_reg),
            .prev_below ((k == 0) ? 1'b1 : stat[(k == 0) ? 0 : k - 1].below),
            .prev_lo    (cell_lo[(k == 0) ? 0 : k - 1]),
            .prev_hi    (cell_hi[(k == 0) ? 0 : k - 1]),
            .next_lo    (cell_lo[(k == MAX_INTERVALS - 1) ? k : k + 1]),
            .next_hi    (cell_hi[(k == MAX_INTERVALS - 1) ? k : k + 1]),
            .lo         (cell_lo[k]),
            .hi         (cell_hi[k]),
            .stat       (stat[k])
        );
    end

    // pick the first joined interval and the hit interval
    always_comb
    begin
        any_join = 1'b0;
        any_hit  = 1'b0;
        join_lo  = '0;
        join_hi  = '0;
        hit_hi   = '0;
        for (int k = 0; k < MAX_INTERVALS; k++)
        begin
            if (stat[k].joins && (k == 0 || !stat[(k == 0) ? 0 : k - 1].joins))
            begin
                join_lo = join_lo | cell_lo[k];
                join_hi = join_hi | cell_hi[k];
            end
            if (stat[k].hit)
                hit_hi = hit_hi | cell_hi[k];
            any_join = any_join | stat[k].joins;
            any_hit  = any_hit | stat[k].hit;
        end
        miss_end = rng_lo_reg - 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        rng_lo_next = rng_lo_reg;
        rng_hi_next = rng_hi_reg;
        joined_next = joined_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        op          = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_WORK;
                    action_next = item.action;
                    rng_lo_next = INDEX_BITS'(item.index_low);
                    rng_hi_next = INDEX_BITS'(item.index_high);
                    joined_next = 1'b0;
                end
            end
            ST_WORK:
            begin
                result_next = '0;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
                unique case (action_reg)
                    ACT_CLEAR:
                        count_next = '0;
                    ACT_QUERY:
                    begin
                        result_next.hit          = any_hit;
                        result_next.interval_end = any_hit ? 16'(hit_hi) : 16'(miss_end);
                    end
                    ACT_ADD:
                    begin
                        if (rng_lo_reg > rng_hi_reg)
                        begin
                            count_next = count_reg;
                        end
                        else if (any_join)
                        begin
                            // fold one joined interval, keep going
                            op          = CELL_ABSORB;
                            rng_lo_next = (join_lo < rng_lo_reg) ? join_lo : rng_lo_reg;
                            rng_hi_next = (join_hi > rng_hi_reg) ? join_hi : rng_hi_reg;
                            count_next  = count_reg - 1'b1;
                            joined_next = 1'b1;
                            done_next   = 1'b0;
                            state_next  = ST_WORK;
                        end
                        else if (!joined_reg && count_reg == CW'(MAX_INTERVALS))
                        begin
                            result_next.overflow = 1'b1;
                        end
                        else
                        begin
                            op         = CELL_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    default:
                        count_next = count_reg;
                endcase
                result_next.interval_count = 7'(count_next);
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            joined_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            joined_reg <= joined_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        rng_lo_reg <= rng_lo_next;
        rng_hi_reg <= rng_hi_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

### bench/register_interval_set_tb.sv
// testbench for the register interval set: directed and random items checked against a predictor
`default_nettype none

module register_interval_set_tb;
    import ris_pkg::*;

    localparam int TABLE_DEPTH = 64;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    done;
    result_t result;

    // predicted interval set
    logic [15:0] span_lo [$];
    logic [15:0] span_hi [$];
    result_t     expected_results [$];
    int          fail_count;

    register_interval_set dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // merge an inclusive range into the predicted set, returns overflow
    function automatic logic merge_span(input logic [15:0] b, input logic [15:0] e);
        int first;
        int last;
        logic [15:0] nb;
        logic [15:0] ne;
        first = 0;
        while (first < span_lo.size() && {1'b0, span_hi[first]} + 17'd1 < {1'b0, b})
            first++;
        last = first;
        while (last < span_lo.size() && {1'b0, span_lo[last]} <= {1'b0, e} + 17'd1)
            last++;
        if (last == first)
        begin
            if (span_lo.size() >= TABLE_DEPTH)
                return 1'b1;
            span_lo.insert(first, b);
            span_hi.insert(first, e);
            return 1'b0;
        end
        nb = (span_lo[first] < b) ? span_lo[first] : b;
        ne = (span_hi[last - 1] > e) ? span_hi[last - 1] : e;
        for (int k = first; k < last; k++)
        begin
            span_lo.delete(first);
            span_hi.delete(first);
        end
        span_lo.insert(first, nb);
        span_hi.insert(first, ne);
        return 1'b0;
    endfunction

    // expected result of one item, updating the predicted set
    function automatic result_t predict_interval_result(input item_t it);
        result_t r;
        r = '0;
        case (it.action)
            ACT_CLEAR:
            begin
                span_lo.delete();
                span_hi.delete();
            end
            ACT_ADD:
            begin
                if (it.index_low <= it.index_high)
                    r.overflow = merge_span(it.index_low, it.index_high);
            end
            ACT_QUERY:
            begin
                r.interval_end = it.index_low - 16'd1;
                for (int k = 0; k < span_lo.size(); k++)
                begin
                    if (it.index_low >= span_lo[k] && it.index_low <= span_hi[k])
                    begin
                        r.hit = 1'b1;
                        r.interval_end = span_hi[k];
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.interval_count = 7'(span_lo.size());
        return r;
    endfunction

    // random gap, mostly short
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
            start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // send one item and wait for its acceptance
    task automatic send_item(input action_t act, input logic [15:0] lo, input logic [15:0] hi);
        item_t it;
        it.action = act;
        it.index_low = lo;
        it.index_high = hi;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_interval_result(it));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.hit !== exp_r.hit)
                begin
                    $error("hit expected %0d actual %0d", exp_r.hit, result.hit);
                    fail_count++;
                end
                if (result.interval_end !== exp_r.interval_end)
                begin
                    $error("interval_end expected %0d actual %0d",
                           exp_r.interval_end, result.interval_end);
                    fail_count++;
                end
                if (result.overflow !== exp_r.overflow)
                begin
                    $error("overflow expected %0d actual %0d", exp_r.overflow, result.overflow);
                    fail_count++;
                end
                if (result.interval_count !== exp_r.interval_count)
                begin
                    $error("interval_count expected %0d actual %0d",
                           exp_r.interval_count, result.interval_count);
                    fail_count++;
                end
            end
        end
    end

    // extremes, every action, reversed range, wrap on query of zero, unused action
    task automatic test_directed();
        send_item(ACT_QUERY, 16'd0, 16'd0);
        send_item(ACT_ADD, 16'd0, 16'd0);
        send_item(ACT_ADD, 16'hFFFF, 16'hFFFF);
        send_item(ACT_QUERY, 16'd0, 16'hFFFF);
        send_item(ACT_QUERY, 16'hFFFF, 16'd0);
        send_item(ACT_QUERY, 16'd1, 16'd0);
        send_item(ACT_ADD, 16'd10, 16'd5);
        send_item(ACT_ADD, 16'd2, 16'd4);
        send_item(ACT_ADD, 16'd1, 16'd1);
        send_item(ACT_QUERY, 16'd3, 16'd0);
        send_item(ACT_NONE, 16'hFFFF, 16'hFFFF);
        send_item(ACT_ADD, 16'd100, 16'hFFFE);
        send_item(ACT_QUERY, 16'h8000, 16'h5555);
        send_item(ACT_CLEAR, 16'hAAAA, 16'h5555);
        send_item(ACT_QUERY, 16'd0, 16'd0);
        send_item(ACT_ADD, 16'd0, 16'hFFFF);
        send_item(ACT_QUERY, 16'h1234, 16'd0);
        send_item(ACT_CLEAR, 16'd0, 16'd0);
    endtask

    // fill the table with disjoint spans, then overflow and a joining add
    task automatic test_full_table();
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_item(ACT_ADD, 16'(k * 4), 16'(k * 4 + 1));
        send_item(ACT_ADD, 16'd1000, 16'd1000);
        send_item(ACT_ADD, 16'd2, 16'd2);
        send_item(ACT_ADD, 16'd1000, 16'd1000);
        send_item(ACT_ADD, 16'd1, 16'd200);
        send_item(ACT_QUERY, 16'd150, 16'd0);
        wait_drained();
        send_item(ACT_CLEAR, 16'd0, 16'd0);
    endtask

    // random mix, small windows so spans merge and the table fills
    task automatic test_random();
        logic [15:0] a;
        logic [15:0] b;
        int sel;
        for (int n = 0; n < 1500; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
            begin
                send_item(ACT_CLEAR, 16'($urandom), 16'($urandom));
            end
            else if (sel < 50)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
                else
                begin
                    a = 16'($urandom_range(0, 600));
                    b = a + 16'($urandom_range(0, 6));
                end
                send_item(ACT_ADD, a, b);
            end
            else if (sel < 97)
            begin
                a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 620));
                send_item(ACT_QUERY, a, 16'($urandom));
            end
            else
            begin
                send_item(ACT_NONE, 16'($urandom), 16'($urandom));
            end
            if (n == 700)
                wait_drained();
            idle_gap();
        end
    endtask

    initial
    begin
        fail_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_full_table();
        test_random();
        wait_drained();
        repeat (200) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("register_interval_set verification clean");
        else
            $display("register_interval_set verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("register_interval_set verification failed");
        $finish;
    end

endmodule

`default_nettype wire
